[design/fccw_pkg.sv]
// ----------------------------------------------------------------------------
// fccw_pkg: shared types and codes for the FAT12 cluster chain walker
// Holds the item payload structs, the item kind and status codes, the
// register index codes and the fixed FAT12 constants.
// ----------------------------------------------------------------------------
package fccw_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_ACCEPTED = 3'd0;
    localparam logic [2:0] STAT_CLUSTER  = 3'd1;
    localparam logic [2:0] STAT_BAD      = 3'd2;
    localparam logic [2:0] STAT_NO_CHAIN = 3'd3;
    localparam logic [2:0] STAT_BROKEN   = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
    localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
    localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
    localparam logic [2:0] REG_TABLE_COPIES        = 3'd3;
    localparam logic [2:0] REG_ROOT_ENTRIES        = 3'd4;
    localparam logic [2:0] REG_TABLE_SECTORS       = 3'd5;

    // Table entry marks.
    localparam logic [11:0] ENTRY_BAD = 12'hFF7;
    localparam logic [11:0] ENTRY_END = 12'hFF8;

    // Root directory entries are 32 bytes, so the byte count is a shift by 5.
    localparam int DIR_ENTRY_SHIFT = 5;

    // Dividend of the root sector division is 22 bits wide: one step per bit.
    localparam int DIV_WIDTH = 22;
    localparam logic [4:0] DIV_LAST_STEP = 5'(DIV_WIDTH - 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] byte_index;
        logic [7:0]  byte_value;
        logic [11:0] start_cluster;
    } fccw_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] cluster_number;
        logic [31:0] cluster_address;
        logic [11:0] next_entry;
        logic        last;
    } fccw_out_t;

endpackage

[design/fat12_cluster_chain_walker.sv]
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker: follows FAT12 cluster chains in a byte table
// Results: load and start items, and an advance without a live chain or on a
//   chain at a cluster below two, give their result in the cycle after
//   acceptance; other advances pass the table read, the multiply and the add.
// Throughput: one item per cycle for load, start and an advance without a live
//   chain while the output register is free or being taken; no item is taken
//   while an advance is in READ or ADD.
// Reset: control state clears and the data base is computed from the reset
//   register values; no item is taken until the recompute is through BASE,
//   and the same recompute runs after every register write.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker #(
    parameter int TABLE_BYTES = 8192
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  fccw_pkg::fccw_in_t s_item,

    output logic               m_valid,
    input  logic               m_ready,
    output fccw_pkg::fccw_out_t m_item,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fccw_pkg::*;

    // The table is split into an even-byte bank and an odd-byte bank, so the
    // two bytes of an entry pair always come from different banks and are
    // read in the same cycle.
    localparam int BANK_DEPTH = TABLE_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam logic [13:0] TABLE_LIMIT = 14'(TABLE_BYTES);

    // The sequencer: a base recompute after reset or a register write
    // (INIT, DIV, SUM, BASE), then items in IDLE; an advance on a live chain
    // at cluster 2 or above passes through READ and ADD.
    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_BASE = 7'b0001000,
        S_IDLE = 7'b0010000,
        S_READ = 7'b0100000,
        S_ADD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] reserved_reg;
    logic [7:0]  copies_reg;
    logic [15:0] root_reg;
    logic [15:0] tsec_reg;

    // Chain state.
    logic [11:0] cur_reg, cur_next;
    logic        active_reg, active_next;

    // Root sector division, restoring, one quotient bit per cycle.
    logic [21:0] div_n_reg, div_n_next;
    logic [12:0] div_r_reg, div_r_next;
    logic [21:0] div_q_reg, div_q_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;

    // Geometry results: sectors before the data area, bytes per cluster and
    // the data base in bytes.
    logic [24:0] sum_reg, sum_next;
    logic [20:0] clbytes_reg, clbytes_next;
    logic [37:0] base_reg, base_next;
    logic [32:0] prod_reg, prod_next;

    // Output register.
    logic      m_valid_reg, m_valid_next;
    fccw_out_t m_item_reg, m_item_next;

    // Table memories and their registered read data.
    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];
    logic [7:0] even_rd_reg;
    logic [7:0] odd_rd_reg;
    logic       off_odd_reg;
    logic       lo_oob_reg;
    logic       hi_oob_reg;

    logic        accept;
    logic        cfg_wr;
    logic [12:0] entry_off;
    logic [12:0] even_addr;
    logic [11:0] odd_addr;
    logic [13:0] hi_pos;
    logic        load_hit;
    logic [13:0] trial;
    logic [23:0] tc_prod;
    logic [21:0] dividend;
    logic [7:0]  lo_byte;
    logic [7:0]  hi_byte;
    logic [15:0] pair;
    logic [11:0] entry;
    logic [11:0] cl_off;
    logic [38:0] addr_sum;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            REG_BYTES_PER_SECTOR:    prdata = 32'(bps_reg);
            REG_SECTORS_PER_CLUSTER: prdata = 32'(spc_reg);
            REG_RESERVED_SECTORS:    prdata = 32'(reserved_reg);
            REG_TABLE_COPIES:        prdata = 32'(copies_reg);
            REG_ROOT_ENTRIES:        prdata = 32'(root_reg);
            REG_TABLE_SECTORS:       prdata = 32'(tsec_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    // The entry of cluster c starts at byte c + c/2. The banks are read from
    // the current cluster every cycle; in READ the data belongs to the cycle
    // in which the advance was accepted, and the cluster has not moved since.
    assign entry_off = 13'(cur_reg) + 13'(cur_reg[11:1]);
    assign odd_addr  = entry_off[12:1];
    assign even_addr = entry_off[0] ? (13'(odd_addr) + 13'd1) : 13'(odd_addr);
    assign hi_pos    = 14'(entry_off) + 14'd1;
    assign load_hit  = accept && (s_item.kind == KIND_LOAD) &&
                       (14'(s_item.byte_index) < TABLE_LIMIT);

    always_ff @(posedge aclk) begin
        if (load_hit) begin
            if (s_item.byte_index[0]) begin
                odd_mem[s_item.byte_index[BANK_AW:1]] <= s_item.byte_value;
            end else begin
                even_mem[s_item.byte_index[BANK_AW:1]] <= s_item.byte_value;
            end
        end
        even_rd_reg <= even_mem[even_addr[BANK_AW-1:0]];
        odd_rd_reg  <= odd_mem[odd_addr[BANK_AW-1:0]];
        off_odd_reg <= entry_off[0];
        lo_oob_reg  <= 14'(entry_off) >= TABLE_LIMIT;
        hi_oob_reg  <= hi_pos >= TABLE_LIMIT;
    end

    // Entry assembly from the little-endian pair; bytes past the table read
    // as zero.
    assign lo_byte = lo_oob_reg ? 8'd0 : (off_odd_reg ? odd_rd_reg : even_rd_reg);
    assign hi_byte = hi_oob_reg ? 8'd0 : (off_odd_reg ? even_rd_reg : odd_rd_reg);
    assign pair    = {hi_byte, lo_byte};
    assign entry   = cur_reg[0] ? pair[15:4] : pair[11:0];

    assign trial    = {div_r_reg, div_n_reg[21]};
    assign tc_prod  = 24'(tsec_reg) * 24'(copies_reg);
    assign dividend = ({6'd0, root_reg} << DIR_ENTRY_SHIFT) + 22'(bps_reg) - 22'd1;
    assign cl_off   = cur_reg - 12'd2;
    assign addr_sum = {1'b0, base_reg} + 39'(prod_reg);

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        active_next  = active_reg;
        div_n_next   = div_n_reg;
        div_r_next   = div_r_reg;
        div_q_next   = div_q_reg;
        div_cnt_next = div_cnt_reg;
        sum_next     = sum_reg;
        clbytes_next = clbytes_reg;
        base_next    = base_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                div_n_next   = dividend;
                div_r_next   = 13'd0;
                div_q_next   = 22'd0;
                div_cnt_next = DIV_LAST_STEP;
                state_next   = S_DIV;
            end
            S_DIV: begin
                div_n_next = {div_n_reg[20:0], 1'b0};
                if (trial >= {1'b0, bps_reg}) begin
                    div_r_next = 13'(trial - {1'b0, bps_reg});
                    div_q_next = {div_q_reg[20:0], 1'b1};
                end else begin
                    div_r_next = trial[12:0];
                    div_q_next = {div_q_reg[20:0], 1'b0};
                end
                if (div_cnt_reg == 5'd0) begin
                    state_next = S_SUM;
                end else begin
                    div_cnt_next = div_cnt_reg - 5'd1;
                end
            end
            S_SUM: begin
                // A zero sector size has no root directory term.
                sum_next = 25'(reserved_reg) + 25'(tc_prod) +
                           ((bps_reg == 13'd0) ? 25'd0 : 25'(div_q_reg));
                clbytes_next = 21'(spc_reg) * 21'(bps_reg);
                state_next   = S_BASE;
            end
            S_BASE: begin
                base_next  = 38'(bps_reg) * 38'(sum_reg);
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    m_item_next  = '0;
                    m_valid_next = 1'b1;
                    m_item_next.status = STAT_ACCEPTED;
                    case (s_item.kind)
                        KIND_START: begin
                            cur_next    = s_item.start_cluster;
                            active_next = (s_item.start_cluster != 12'd0);
                        end
                        KIND_ADVANCE: begin
                            if (!active_reg) begin
                                m_item_next.status = STAT_NO_CHAIN;
                            end else if (cur_reg < 12'd2) begin
                                m_item_next.status         = STAT_BROKEN;
                                m_item_next.cluster_number = cur_reg;
                                m_item_next.last           = 1'b1;
                                active_next                = 1'b0;
                            end else begin
                                // Result goes out from ADD.
                                m_valid_next = 1'b0;
                                state_next   = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                m_item_next.cluster_number = cur_reg;
                m_item_next.next_entry     = entry;
                m_item_next.last           = 1'b0;
                prod_next = 33'(cl_off) * 33'(clbytes_reg);
                if (entry == ENTRY_BAD) begin
                    m_item_next.status = STAT_BAD;
                    m_item_next.last   = 1'b1;
                    active_next        = 1'b0;
                end else if (entry < 12'd2) begin
                    m_item_next.status = STAT_BROKEN;
                    m_item_next.last   = 1'b1;
                    active_next        = 1'b0;
                end else begin
                    m_item_next.status = STAT_CLUSTER;
                    if (entry >= ENTRY_END) begin
                        m_item_next.last = 1'b1;
                        active_next      = 1'b0;
                    end else begin
                        cur_next = entry;
                    end
                end
                state_next = S_ADD;
            end
            S_ADD: begin
                // Addresses past 32 bits saturate.
                if (m_item_reg.status == STAT_CLUSTER) begin
                    m_item_next.cluster_address = (addr_sum[38:32] != 7'd0) ?
                                                  32'hFFFF_FFFF : addr_sum[31:0];
                end else begin
                    m_item_next.cluster_address = 32'd0;
                end
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_INIT;
            end
        endcase

        // Any register write restarts the data base computation.
        if (cfg_wr) begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            cur_reg      <= 12'd0;
            active_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            bps_reg      <= 13'd512;
            spc_reg      <= 8'd1;
            reserved_reg <= 16'd1;
            copies_reg   <= 8'd2;
            root_reg     <= 16'd224;
            tsec_reg     <= 16'd9;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_BYTES_PER_SECTOR:    bps_reg      <= pwdata[12:0];
                    REG_SECTORS_PER_CLUSTER: spc_reg      <= pwdata[7:0];
                    REG_RESERVED_SECTORS:    reserved_reg <= pwdata[15:0];
                    REG_TABLE_COPIES:        copies_reg   <= pwdata[7:0];
                    REG_ROOT_ENTRIES:        root_reg     <= pwdata[15:0];
                    REG_TABLE_SECTORS:       tsec_reg     <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        div_n_reg   <= div_n_next;
        div_r_reg   <= div_r_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        sum_reg     <= sum_next;
        clbytes_reg <= clbytes_next;
        base_reg    <= base_next;
        prod_reg    <= prod_next;
        m_item_reg  <= m_item_next;
    end

endmodule

[verif/fat12_cluster_chain_walker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_tb: self-checking bench for the FAT12 chain walker
// Loads allocation table entries, starts chains and walks them through the
// item channel while the geometry registers are changed between phases. An
// internal model of the table, the walk state and the geometry predicts every
// result, and the results are checked field by field in order.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_tb;
    import fccw_pkg::*;

    localparam int TABLE_BYTES = 8192;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 228;
    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX = 10;

    // Kind code 3 has no meaning in the block; it must be answered as accepted.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Clusters 0 and 1 are reserved in FAT12; data clusters start at 2.
    localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;
    // Highest entry value that still links to another cluster.
    localparam logic [11:0] LINK_MAX = ENTRY_BAD - 12'd1;

    typedef struct {
        int unsigned bps;
        int unsigned spc;
        int unsigned rsv;
        int unsigned copies;
        int unsigned root;
        int unsigned tsec;
    } geometry_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts at a known
    // value so nothing floats before the driver takes over.
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    fccw_in_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    fccw_out_t   m_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #6 aclk = ~aclk;

    fat12_cluster_chain_walker #(
        .TABLE_BYTES(TABLE_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state. The stimulus side keeps its own image of the table bytes it
    // has written so that no advance ever reads a byte that was never loaded.
    // The predictor keeps a separate image that follows accepted items only.
    // ------------------------------------------------------------------------
    fccw_in_t    send_items [$];
    fccw_out_t   results_due [$];
    bit [7:0]    stim_table [TABLE_BYTES];
    bit          stim_written [TABLE_BYTES];
    int unsigned items_queued = 0;

    bit [7:0]    fat_image [TABLE_BYTES];
    logic [11:0] walk_cluster = '0;
    bit          walk_live = 1'b0;

    // Geometry as the block holds it, starting from the reset values.
    logic [12:0] geo_bps = 13'd512;
    logic [7:0]  geo_spc = 8'd1;
    logic [15:0] geo_rsv = 16'd1;
    logic [7:0]  geo_copies = 8'd2;
    logic [15:0] geo_root = 16'd224;
    logic [15:0] geo_tsec = 16'd9;

    int          send_gap_pct = 0;
    int          sink_stall_pct = 0;
    bit          in_fire = 1'b0;
    int unsigned items_taken = 0;
    int unsigned results_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    fccw_out_t   due;
    string       bad_fields;

    int send_gap_by_mode [4] = '{0, 68, 0, 14};
    int sink_stall_by_mode [4] = '{0, 0, 68, 14};

    // ------------------------------------------------------------------------
    // Predictor. The 12-bit entry of a cluster sits in the little-endian byte
    // pair at cluster*3/2: an even cluster owns the low 12 bits, an odd one the
    // high 12. Bytes past the end of the table read as zero.
    // ------------------------------------------------------------------------
    function automatic logic [11:0] fat_entry(logic [11:0] cl);
        int          off;
        logic [15:0] pair;
        off = (int'(cl) * 3) / 2;
        pair[7:0]  = (off < TABLE_BYTES) ? fat_image[off] : 8'h00;
        pair[15:8] = (off + 1 < TABLE_BYTES) ? fat_image[off + 1] : 8'h00;
        return cl[0] ? pair[15:4] : pair[11:0];
    endfunction

    // The data area begins after the reserved sectors, every table copy and the
    // root directory, which is rounded up to whole sectors. With a zero sector
    // size the root term is zero and so is every address. Results above the
    // 32-bit range clamp to all ones.
    function automatic logic [31:0] cluster_byte_addr(logic [11:0] cl);
        longint unsigned bps;
        longint unsigned root_secs;
        longint unsigned base;
        longint unsigned addr;
        bps = 64'(geo_bps);
        root_secs = 0;
        if (bps != 0)
            root_secs = (64'(geo_root) * 64'd32 + bps - 64'd1) / bps;
        base = bps * (64'(geo_rsv) + 64'(geo_tsec) * 64'(geo_copies) + root_secs);
        addr = base + (64'(cl) - 64'(FIRST_DATA_CLUSTER)) * 64'(geo_spc) * bps;
        if (addr > 64'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return addr[31:0];
    endfunction

    // Works out the one result of an item and moves the walk state on.
    function automatic fccw_out_t chain_step(fccw_in_t it);
        fccw_out_t   r;
        logic [11:0] ent;
        r = '0;
        r.status = STAT_ACCEPTED;
        case (it.kind)
            KIND_LOAD: begin
                if (int'(it.byte_index) < TABLE_BYTES)
                    fat_image[it.byte_index] = it.byte_value;
            end
            KIND_START: begin
                walk_cluster = it.start_cluster;
                walk_live = (it.start_cluster != 12'd0);
            end
            KIND_ADVANCE: begin
                if (!walk_live) begin
                    r.status = STAT_NO_CHAIN;
                end else begin
                    r.cluster_number = walk_cluster;
                    if (walk_cluster < FIRST_DATA_CLUSTER) begin
                        // A chain started on cluster 1 has nothing to read.
                        r.status = STAT_BROKEN;
                        r.last = 1'b1;
                        walk_live = 1'b0;
                    end else begin
                        ent = fat_entry(walk_cluster);
                        r.next_entry = ent;
                        if (ent == ENTRY_BAD) begin
                            r.status = STAT_BAD;
                            r.last = 1'b1;
                            walk_live = 1'b0;
                        end else if (ent < FIRST_DATA_CLUSTER) begin
                            r.status = STAT_BROKEN;
                            r.last = 1'b1;
                            walk_live = 1'b0;
                        end else begin
                            r.status = STAT_CLUSTER;
                            r.cluster_address = cluster_byte_addr(walk_cluster);
                            if (ent >= ENTRY_END) begin
                                r.last = 1'b1;
                                walk_live = 1'b0;
                            end else begin
                                walk_cluster = ent;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Inputs change on the falling edge. A new item is only presented
    // once the previous one was taken at the last rising edge, so valid and
    // the payload hold steady until the handshake completes.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_fire) begin
                if (send_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_item  <= send_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic flag_mismatch(string msg);
        if (mismatch_count < REPORT_MAX)
            $display("%0t: result %0d: %s", $time, results_taken, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor. On every rising edge an accepted input item is run through the
    // predictor, and an accepted result is checked against the oldest
    // expectation. The expectation is queued first so that a result leaving
    // on the same edge as its own item would still find it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        in_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                results_due = {results_due, chain_step(s_item)};
                items_taken <= items_taken + 1;
            end
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if (results_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result st=%0d cl=%0d",
                                            m_item.status, m_item.cluster_number));
                end else begin
                    due = results_due.pop_front();
                    bad_fields = "";
                    if (m_item.status !== due.status)
                        bad_fields = {bad_fields, " status"};
                    if (m_item.cluster_number !== due.cluster_number)
                        bad_fields = {bad_fields, " cluster_number"};
                    if (m_item.cluster_address !== due.cluster_address)
                        bad_fields = {bad_fields, " cluster_address"};
                    if (m_item.next_entry !== due.next_entry)
                        bad_fields = {bad_fields, " next_entry"};
                    if (m_item.last !== due.last)
                        bad_fields = {bad_fields, " last"};
                    if (bad_fields != "")
                        flag_mismatch($sformatf(
                            "bad%s: exp st=%0d cl=%h addr=%h ent=%h last=%0d, got st=%0d cl=%h addr=%h ent=%h last=%0d",
                            bad_fields, due.status, due.cluster_number, due.cluster_address,
                            due.next_entry, due.last, m_item.status, m_item.cluster_number,
                            m_item.cluster_address, m_item.next_entry, m_item.last));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("fat12_cluster_chain_walker_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Fields that the kind does not use are filled at random; the block must
    // ignore them.
    task automatic queue_item(logic [1:0] kind, logic [12:0] index, logic [7:0] value,
                              logic [11:0] first);
        fccw_in_t it;
        it.kind = kind;
        it.byte_index = 13'($urandom);
        it.byte_value = 8'($urandom);
        it.start_cluster = 12'($urandom);
        if (kind == KIND_LOAD) begin
            it.byte_index = index;
            it.byte_value = value;
            stim_table[index] = value;
            stim_written[index] = 1'b1;
        end
        if (kind == KIND_START)
            it.start_cluster = first;
        if (kind != KIND_UNUSED)
            items_queued++;
        send_items = {send_items, it};
    endtask

    // Writes one 12-bit entry as two byte loads. The nibble shared with the
    // neighbor cluster keeps what was loaded before, or gets random bits if
    // that byte was never loaded.
    task automatic put_entry(logic [11:0] cl, logic [11:0] entry);
        int          off;
        logic [15:0] pair;
        off = (int'(cl) * 3) / 2;
        pair[7:0]  = stim_written[off] ? stim_table[off] : 8'($urandom);
        pair[15:8] = stim_written[off + 1] ? stim_table[off + 1] : 8'($urandom);
        if (cl[0])
            pair[15:4] = entry;
        else
            pair[11:0] = entry;
        queue_item(KIND_LOAD, 13'(off), pair[7:0], '0);
        queue_item(KIND_LOAD, 13'(off + 1), pair[15:8], '0);
    endtask

    // Builds a chain of n distinct clusters, loads all of its entries, then
    // starts it and walks it. The chain ends in an end mark, a bad-cluster
    // mark, a broken link or a loop back into itself. Some walks stop early,
    // some go one step past the end.
    task automatic queue_chain(int n);
        logic [11:0] nodes [$];
        bit          picked [4096];
        logic [11:0] c;
        logic [11:0] tail;
        bit          loops;
        int          steps;
        int          r;
        while (nodes.size() < n) begin
            if (nodes.size() == 0)
                c = 12'($urandom_range(FIRST_DATA_CLUSTER, 4095));
            else if ($urandom_range(1) == 1 && nodes[$] < LINK_MAX)
                c = nodes[$] + 12'd1;
            else
                c = 12'($urandom_range(FIRST_DATA_CLUSTER, LINK_MAX));
            // Later nodes are reached through links, so they must be valid
            // link values as well as unused in this chain.
            if (!picked[c] && (nodes.size() == 0 || c <= LINK_MAX)) begin
                picked[c] = 1'b1;
                nodes = {nodes, c};
            end
        end
        loops = 1'b0;
        r = $urandom_range(99);
        if (r < 55) begin
            tail = 12'($urandom_range(ENTRY_END, 12'hFFF));
        end else if (r < 70) begin
            tail = ENTRY_BAD;
        end else if (r < 82) begin
            tail = 12'($urandom_range(0, 1));
        end else begin
            tail = nodes[$urandom_range(0, n - 1)];
            if (tail > LINK_MAX)
                tail = ENTRY_END;
            else
                loops = 1'b1;
        end
        for (int i = 0; i < n - 1; i++)
            put_entry(nodes[i], nodes[i + 1]);
        put_entry(nodes[n - 1], tail);
        queue_item(KIND_START, '0, '0, nodes[0]);
        if ($urandom_range(9) == 0)
            steps = $urandom_range(0, n - 1);
        else if (loops)
            steps = n + $urandom_range(0, 2 * n + 2);
        else
            steps = n + $urandom_range(0, 1);
        repeat (steps) queue_item(KIND_ADVANCE, '0, '0, '0);
    endtask

    // One group of random stimulus: mostly complete chains, the rest stray
    // loads, stray starts, advances with no chain and unused kinds.
    task automatic queue_random_group();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            queue_chain(($urandom_range(99) < 85) ? $urandom_range(1, 6)
                                                   : $urandom_range(7, 24));
        end else if (r < 80) begin
            repeat ($urandom_range(1, 4))
                queue_item(KIND_LOAD, 13'($urandom), 8'($urandom), '0);
        end else if (r < 87) begin
            // A start that is never walked; the next group starts afresh.
            queue_item(KIND_START, '0, '0, 12'($urandom));
        end else if (r < 95) begin
            // Cluster 0 leaves no chain, cluster 1 is a broken link.
            queue_item(KIND_START, '0, '0, 12'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3)) queue_item(KIND_ADVANCE, '0, '0, '0);
        end else begin
            queue_item(KIND_UNUSED, '0, '0, '0);
        end
    endtask

    // Waits until every queued item was taken and every result came back.
    // The counters are updated by nonblocking assignment, so their values at
    // the rising edge are stable.
    task automatic wait_drained();
        do @(posedge aclk);
        while (send_items.size() != 0 || s_valid || items_taken != results_taken);
    endtask

    // A register write: setup cycle, then access cycle; the register takes the
    // value at the rising edge that ends the access cycle.
    task automatic write_reg(logic [2:0] idx, int unsigned value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BYTES_PER_SECTOR:    geo_bps = 13'(value);
            REG_SECTORS_PER_CLUSTER: geo_spc = 8'(value);
            REG_RESERVED_SECTORS:    geo_rsv = 16'(value);
            REG_TABLE_COPIES:        geo_copies = 8'(value);
            REG_ROOT_ENTRIES:        geo_root = 16'(value);
            REG_TABLE_SECTORS:       geo_tsec = 16'(value);
            default: ;
        endcase
    endtask

    task automatic set_geometry(geometry_t g);
        write_reg(REG_BYTES_PER_SECTOR, g.bps);
        write_reg(REG_SECTORS_PER_CLUSTER, g.spc);
        write_reg(REG_RESERVED_SECTORS, g.rsv);
        write_reg(REG_TABLE_COPIES, g.copies);
        write_reg(REG_ROOT_ENTRIES, g.root);
        write_reg(REG_TABLE_SECTORS, g.tsec);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    geometry_t plan [PHASE_COUNT];
    int unsigned phase_end;
    int unsigned phase_half;
    bit          paused;
    int          mode;

    initial begin
        // A plain 1.44 MB floppy, the top of every documented range (mostly
        // saturating addresses), the bottom of those ranges, all zero, all
        // ones, and three random geometries.
        plan[0] = '{512, 1, 1, 2, 224, 9};
        plan[1] = '{4096, 128, 65535, 255, 65535, 65535};
        plan[2] = '{1, 1, 0, 1, 0, 1};
        plan[3] = '{0, 0, 0, 0, 0, 0};
        plan[4] = '{8191, 255, 65535, 255, 65535, 65535};
        plan[5] = '{$urandom_range(0, 8191), $urandom_range(0, 255),
                    $urandom_range(0, 65535), $urandom_range(0, 255),
                    $urandom_range(0, 65535), $urandom_range(0, 65535)};
        for (int i = 6; i < PHASE_COUNT; i++)
            plan[i] = '{1 << $urandom_range(7, 12), 1 << $urandom_range(0, 7),
                        $urandom_range(1, 32), $urandom_range(1, 2),
                        $urandom_range(0, 1024), $urandom_range(1, 12)};

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with the reset geometry and no idling.
        queue_item(KIND_ADVANCE, '0, '0, '0);           // advance before any start
        queue_item(KIND_START, '0, '0, 12'd0);          // empty chain
        queue_item(KIND_ADVANCE, '0, '0, '0);
        queue_item(KIND_START, '0, '0, 12'd1);          // cluster below two
        queue_item(KIND_ADVANCE, '0, '0, '0);
        queue_item(KIND_UNUSED, '0, '0, '0);
        queue_item(KIND_LOAD, 13'h1FFF, 8'hFF, '0);     // last table byte
        put_entry(12'd2, 12'd3);
        put_entry(12'd3, 12'hFFF);                      // end mark
        put_entry(12'd4, ENTRY_BAD);
        put_entry(12'd5, 12'd1);                        // broken link
        queue_item(KIND_START, '0, '0, 12'd2);
        repeat (3) queue_item(KIND_ADVANCE, '0, '0, '0);
        queue_item(KIND_START, '0, '0, 12'd4);
        queue_item(KIND_ADVANCE, '0, '0, '0);
        queue_item(KIND_START, '0, '0, 12'd5);
        queue_item(KIND_ADVANCE, '0, '0, '0);
        put_entry(12'hFFF, ENTRY_END);                  // highest cluster
        queue_item(KIND_START, '0, '0, 12'hFFF);
        queue_item(KIND_ADVANCE, '0, '0, '0);
        wait_drained();

        // Random phases. Each one changes the geometry while the block is
        // idle, then runs with its own idling pattern. Halfway through, the
        // sender holds back until every result is in, and the pattern moves
        // on to the next one.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_geometry(plan[p]);
            mode = p % 4;
            send_gap_pct = send_gap_by_mode[mode];
            sink_stall_pct = sink_stall_by_mode[mode];
            phase_end = items_queued + PHASE_ITEMS;
            phase_half = items_queued + PHASE_ITEMS / 2;
            paused = 1'b0;
            while (items_queued < phase_end) begin
                if (!paused && items_queued >= phase_half) begin
                    wait_drained();
                    mode = (mode + 1) % 4;
                    send_gap_pct = send_gap_by_mode[mode];
                    sink_stall_pct = sink_stall_by_mode[mode];
                    paused = 1'b1;
                end
                queue_random_group();
            end
            wait_drained();
        end

        // Give a late stray result time to show up before the verdict.
        repeat (10) @(posedge aclk);
        mismatch_count += results_due.size();
        if (mismatch_count == 0) begin
            $display("fat12_cluster_chain_walker_tb: done, clean");
        end else begin
            $display("fat12_cluster_chain_walker_tb: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
design/fccw_pkg.sv
design/fat12_cluster_chain_walker.sv
verif/fat12_cluster_chain_walker_tb.sv
